FILE: design/ffas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffas_pkg: shared types and constants of the first-fit sub-allocator
// Table depth, field widths, status codes and the layout of one table entry.
// ----------------------------------------------------------------------------
package ffas_pkg;

  // table geometry
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // data path width of offsets and sizes
  localparam int DATA_W = 32;

  // chunk size after reset
  localparam logic [DATA_W-1:0] CHUNK_RESET = 32'd268435456;

  // request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic              free;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] off;
  } entry_t;

endpackage

FILE: design/first_fit_aligned_suballocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_aligned_suballocator: first-fit sub-allocator with alignment
// Keeps a table of blocks of one chunk in a single-port memory and serves
// allocate and free requests by an in-order scan of that table.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low; its result
// shows for one cycle with done high and must be captured then. Entries are
// read from a synchronous memory one per cycle with a power-of-two (or zero)
// alignment and for every free, scanning up to the first hit (at most the
// table fill, up to 64 entries); a split then appends the rest in S_APPEND.
// With any other alignment each scanned entry goes through the 32-step
// remainder unit before the next entry is read. An allocate larger than the
// chunk is answered at once from idle, without a scan. Reset and every
// chunk_size write rewrite entry 0 in S_INIT, with busy high.
// ----------------------------------------------------------------------------
module first_fit_aligned_suballocator (
  input  logic                        clk,
  input  logic                        rst,
  // chunk_size register
  input  logic                        cfg_we,
  input  logic [ffas_pkg::DATA_W-1:0] cfg_wdata,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [ffas_pkg::DATA_W-1:0] req_size,
  input  logic [ffas_pkg::DATA_W-1:0] align,
  input  logic [ffas_pkg::DATA_W-1:0] target_offset,
  input  logic [ffas_pkg::DATA_W-1:0] target_size,
  // result
  output logic                        done,
  output logic [1:0]                  status,
  output logic [ffas_pkg::DATA_W-1:0] granted_offset,
  output logic [ffas_pkg::DATA_W-1:0] granted_size
);
  import ffas_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_APPEND
  } state_t;

  state_t            state;
  logic [DATA_W-1:0] chunk;
  logic [CNT_W-1:0]  count;

  // latched request
  logic              func_r;
  logic [DATA_W-1:0] req_r;
  logic [DATA_W-1:0] al_r;
  logic [DATA_W-1:0] amask;
  logic              fast;
  logic [DATA_W-1:0] toff_r;
  logic [DATA_W-1:0] tsz_r;

  // scan pipeline
  logic [CNT_W-1:0]  rd_idx;
  logic              p1_v;
  logic [IDX_W-1:0]  p1_idx;
  logic              md_wait;
  logic              p2_v;
  logic [IDX_W-1:0]  p2_idx;
  entry_t            p2_ent;
  logic [DATA_W-1:0] p2_pad;
  logic [DATA_W:0]   h_need;
  logic [DATA_W-1:0] aoff_r;
  logic [DATA_W-1:0] rsz;

  // table memory
  entry_t            mem [MAX_BLOCKS];
  entry_t            rd_data;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  logic              issue;
  logic              hit;
  logic              pipe_empty;
  logic              md_start;
  logic              md_done;
  logic [DATA_W-1:0] md_rem;
  logic              p2_load;
  logic [DATA_W-1:0] pad_new;
  logic [DATA_W:0]   need;
  logic              split;
  logic              table_full;
  logic [DATA_W-1:0] aoff_sum;
  logic              al_pow2;

  assign busy = (state != S_IDLE);

  // zero counts as a power of two (treated as alignment one)
  assign al_pow2 = ((align & (align - DATA_W'(1))) == '0);

  // ---- scan control ----
  assign pipe_empty = !p1_v && !md_wait && !p2_v;
  assign issue      = (state == S_SCAN) && !hit && (rd_idx < count) &&
                      (fast || pipe_empty);
  assign md_start   = (state == S_SCAN) && !fast && p1_v && !md_wait;

  // padding of the entry at the memory output
  always_comb begin
    if (fast) begin
      pad_new = (-rd_data.off) & amask;
    end else if (md_rem != '0) begin
      pad_new = al_r - md_rem;
    end else begin
      pad_new = '0;
    end
  end

  assign p2_load = (state == S_SCAN) && ((fast && p1_v && !hit) || (!fast && md_done));

  // fit / match check on the second stage
  assign need = {1'b0, p2_pad} + {1'b0, req_r};
  always_comb begin
    if (func_r == FUNC_FREE) begin
      hit = p2_v && (p2_ent.off == toff_r) && (p2_ent.size == tsz_r);
    end else begin
      hit = p2_v && p2_ent.free && (need <= {1'b0, p2_ent.size});
    end
  end

  // update values
  assign split      = (h_need != {1'b0, p2_ent.size});
  assign table_full = (count == CNT_W'(MAX_BLOCKS));
  assign aoff_sum   = p2_ent.off + p2_pad;

  // remainder unit for alignments that are not a power of two
  ffas_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (md_start),
    .dividend (rd_data.off),
    .divisor  (al_r),
    .done     (md_done),
    .rem      (md_rem)
  );

  // ---- memory write select ----
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p2_idx;
    mem_wdata = '0;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{free: 1'b1, size: chunk, off: '0};
      end
      S_UPD: begin
        if (func_r == FUNC_FREE) begin
          mem_we    = 1'b1;
          mem_wdata = '{free: 1'b1, size: p2_ent.size, off: p2_ent.off};
        end else if (!(split && table_full)) begin
          mem_we    = 1'b1;
          mem_wdata = '{free: 1'b0, size: req_r, off: aoff_sum};
        end
      end
      S_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = count[IDX_W-1:0];
        mem_wdata = '{free: 1'b1, size: rsz, off: aoff_r + req_r};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // ---- table memory ----
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  // ---- state machine and result registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      chunk   <= CHUNK_RESET;
      count   <= CNT_W'(1);
      done    <= 1'b0;
      p1_v    <= 1'b0;
      p2_v    <= 1'b0;
      md_wait <= 1'b0;
      rd_idx  <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        chunk   <= cfg_wdata;
        state   <= S_INIT;
        p1_v    <= 1'b0;
        p2_v    <= 1'b0;
        md_wait <= 1'b0;
      end else begin
        unique case (state)
          S_INIT: begin
            count <= CNT_W'(1);
            state <= S_IDLE;
          end

          S_IDLE: begin
            if (start) begin
              func_r  <= func;
              req_r   <= req_size;
              al_r    <= (align == '0) ? DATA_W'(1) : align;
              amask   <= (align == '0) ? '0 : align - DATA_W'(1);
              fast    <= (func == FUNC_FREE) || al_pow2;
              toff_r  <= target_offset;
              tsz_r   <= target_size;
              rd_idx  <= '0;
              p1_v    <= 1'b0;
              p2_v    <= 1'b0;
              md_wait <= 1'b0;
              if ((func == FUNC_ALLOC) && (req_size > chunk)) begin
                // larger than the whole chunk: answer at once
                done           <= 1'b1;
                status         <= ST_NOFIT;
                granted_offset <= '0;
                granted_size   <= '0;
              end else begin
                state <= S_SCAN;
              end
            end
          end

          S_SCAN: begin
            if (issue) begin
              rd_idx <= rd_idx + CNT_W'(1);
              p1_idx <= rd_idx[IDX_W-1:0];
            end
            p1_v <= issue;
            if (md_start) begin
              md_wait <= 1'b1;
            end else if (md_done) begin
              md_wait <= 1'b0;
            end
            p2_v <= p2_load;
            if (p2_load) begin
              p2_idx <= p1_idx;
              p2_ent <= rd_data;
              p2_pad <= pad_new;
            end
            if (hit) begin
              // first hit in table order: stop and hold it in stage 2
              h_need <= need;
              p1_v   <= 1'b0;
              p2_v   <= 1'b0;
              state  <= S_UPD;
            end else if (pipe_empty && (rd_idx >= count)) begin
              done           <= 1'b1;
              status         <= (func_r == FUNC_FREE) ? ST_NOTFOUND : ST_NOFIT;
              granted_offset <= '0;
              granted_size   <= '0;
              state          <= S_IDLE;
            end
          end

          S_UPD: begin
            if (func_r == FUNC_FREE) begin
              done           <= 1'b1;
              status         <= ST_OK;
              granted_offset <= '0;
              granted_size   <= '0;
              state          <= S_IDLE;
            end else if (split && table_full) begin
              done           <= 1'b1;
              status         <= ST_FULL;
              granted_offset <= '0;
              granted_size   <= '0;
              state          <= S_IDLE;
            end else if (split) begin
              aoff_r <= aoff_sum;
              rsz    <= p2_ent.size - h_need[DATA_W-1:0];
              state  <= S_APPEND;
            end else begin
              done           <= 1'b1;
              status         <= ST_OK;
              granted_offset <= aoff_sum;
              granted_size   <= req_r;
              state          <= S_IDLE;
            end
          end

          S_APPEND: begin
            count          <= count + CNT_W'(1);
            done           <= 1'b1;
            status         <= ST_OK;
            granted_offset <= aoff_r;
            granted_size   <= req_r;
            state          <= S_IDLE;
          end

          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

FILE: design/ffas_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffas_rem: iterative remainder unit
// Restoring division, one quotient bit per cycle; returns dividend % divisor
// with a one-cycle done strobe after DATA_W steps. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module ffas_rem (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [ffas_pkg::DATA_W-1:0] dividend,
  input  logic [ffas_pkg::DATA_W-1:0] divisor,
  output logic                   done,
  output logic [ffas_pkg::DATA_W-1:0] rem
);
  import ffas_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   part;
  logic [DATA_W:0]   part_sh;
  logic [DATA_W:0]   part_next;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    part_sh = {part[DATA_W-1:0], quo[DATA_W-1]};
    if (part_sh >= {1'b0, dvs}) begin
      part_next = part_sh - {1'b0, dvs};
    end else begin
      part_next = part_sh;
    end
  end

  assign rem = part[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= STEP_W'(DATA_W - 1);
        quo     <= dividend;
        dvs     <= divisor;
        part    <= '0;
      end else if (running) begin
        part <= part_next;
        quo  <= {quo[DATA_W-2:0], 1'b0};
        step <= step - STEP_W'(1);
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/ffas_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffas_check: port-level checks of the sub-allocator
// Relates results to the request that caused them and to the busy flag.
// ----------------------------------------------------------------------------
module ffas_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_we,
  input logic                        start,
  input logic                        busy,
  input logic                        func,
  input logic                        done,
  input logic [1:0]                  status,
  input logic [ffas_pkg::DATA_W-1:0] granted_offset,
  input logic [ffas_pkg::DATA_W-1:0] granted_size
);
  import ffas_pkg::*;

  logic last_func;

  // operation of the request last taken
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      last_func <= func;
    end
  end

  // a result is shown only once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // failed requests grant nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((granted_offset == '0) && (granted_size == '0)))
    else $error("grant on failed request");

  // not-found only answers a free; no-fit and full only answer an allocate
  a_status_func: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |->
      ((status == ST_NOTFOUND) == (last_func == FUNC_FREE)))
    else $error("status does not fit request");

  // busy rises only after a request, a reset or a chunk write
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start || rst || cfg_we))
    else $error("busy without cause");

endmodule

bind first_fit_aligned_suballocator ffas_check u_ffas_check (.*);
